@@ design/sh2w_pkg.sv @@
// ============================================================================
// sh2w_pkg
// Shared types, codes and constants of the two-wire sensor bus master.
// ============================================================================
package sh2w_pkg;

    // Number of clock pulses in a connection reset sequence
    localparam int RESET_CLOCKS = 9;

    localparam logic [15:0] READING_INVALID = 16'hFFFF;
    localparam logic [15:0] READING_NO_ACK  = 16'hFFFE;

    // Request kind carried with each input tick
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CMD   = 2'd1,
        OP_RESET = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_ACK  = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP_CODE     = 2'd0,
        CFG_HUMIDITY_CODE = 2'd1,
        CFG_SOFT_RST_CODE = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START    = 5'd1,
        PH_SEND_LO  = 5'd2,
        PH_SEND_HI  = 5'd3,
        PH_ACK_LO   = 5'd4,
        PH_ACK_HI   = 5'd5,
        PH_ACK_END  = 5'd6,
        PH_WAIT     = 5'd7,
        PH_RD_LO    = 5'd8,
        PH_RD_HI    = 5'd9,
        PH_MACK_LO  = 5'd10,
        PH_MACK_HI  = 5'd11,
        PH_FINISH   = 5'd12,
        PH_RST_LO   = 5'd13,
        PH_RST_HI   = 5'd14
    } phase_t;

    typedef struct packed {
        logic [7:0] temp_code;
        logic [7:0] humidity_code;
        logic [7:0] soft_rst_code;
    } codes_t;

    typedef struct packed {
        logic        clock_level;
        logic        data_drive_enable;
        logic        data_level;
        logic        busy;
        logic        done;
        status_t     status;
        logic [15:0] reading;
    } tick_res_t;

    // Start sequence pin pattern, one entry per tick
    function automatic logic start_clk(input logic [2:0] idx);
        logic v;
        unique case (idx)
            3'd1, 3'd2, 3'd4, 3'd5: v = 1'b1;
            default:                v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic start_dat(input logic [2:0] idx);
        logic v;
        unique case (idx)
            3'd0, 3'd1, 3'd5, 3'd6: v = 1'b1;
            default:                v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

@@ design/sensor_two_wire_bus_master.sv @@
// ============================================================================
// sensor_two_wire_bus_master
// Tick-level master for a two-wire humidity and temperature sensor bus.
//
// Each input item is one bus tick: it carries the sampled data line and an
// optional request (command transaction or connection reset), and yields
// exactly one result item with the clock level, the data drive enable and
// level, busy, done, status and the 16-bit reading. A transaction sends the
// start sequence, the command byte MSB first, samples the acknowledge and,
// for the two measurement codes, waits for data low (no timeout) and reads
// two bytes with a master acknowledge between them. Starts that arrive while
// busy are ignored. The block takes one item per clock; the result is
// registered in the cycle after the tick is accepted, and the only throttle
// is the output register: a new item is taken whenever the result register
// is empty or is being drained that cycle. The user must write the three
// codes while idle (not enforced by the block); config index 3 is ignored.
// ============================================================================
module sensor_two_wire_bus_master import sh2w_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    // Config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    // Tick in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] command_byte, [8] data_line_in
    input  logic [1:0]  s_tuser,   // [1:0] op

    // Tick result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] clock_level, [1] data_drive_enable,
                                   // [2] data_level, [3] busy_res,
                                   // [5:4] status, [21:6] reading
    output logic        m_tlast    // done_res: last tick of a sequence
);

    codes_t     codes_reg;
    logic       out_valid_reg;
    tick_res_t  out_reg;
    tick_res_t  seq_res;
    logic       in_accept;

    // Output register frees itself when the consumer takes the item
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.temp_code     <= 8'd3;
            codes_reg.humidity_code <= 8'd5;
            codes_reg.soft_rst_code <= 8'd30;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TEMP_CODE:     codes_reg.temp_code     <= cfg_wdata;
                CFG_HUMIDITY_CODE: codes_reg.humidity_code <= cfg_wdata;
                CFG_SOFT_RST_CODE: codes_reg.soft_rst_code <= cfg_wdata;
                default: ;
            endcase
        end
    end

    sh2w_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (in_accept),
        .op           (op_t'(s_tuser)),
        .command_byte (s_tdata[7:0]),
        .data_line_in (s_tdata[8]),
        .codes        (codes_reg),
        .res          (seq_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_reg <= seq_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.done;
    assign m_tdata  = {2'b00, out_reg.reading, out_reg.status, out_reg.busy,
                       out_reg.data_level, out_reg.data_drive_enable,
                       out_reg.clock_level};

`ifndef NO_ASSERTIONS
    a_idle_result_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[21:4] == '0)
        else $error("status or reading set on a tick without done");

    a_done_is_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[3])
        else $error("done reported outside a busy tick");

    a_result_follows_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid)
        else $error("accepted tick produced no result");
`endif

endmodule

@@ design/sh2w_seq.sv @@
// ============================================================================
// sh2w_seq
// Bus sequencer: holds the transaction state and turns one tick into pins.
// ============================================================================
module sh2w_seq import sh2w_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  op_t         op,
    input  logic [7:0]  command_byte,
    input  logic        data_line_in,
    input  codes_t      codes,
    output tick_res_t   res
);

    phase_t      phase_reg,   phase_next;
    logic [4:0]  step_reg,    step_next;
    logic [3:0]  bit_reg,     bit_next;
    logic [7:0]  shift_reg,   shift_next;
    logic [7:0]  held_reg,    held_next;
    logic [15:0] reading_reg, reading_next;

    phase_t      eff_phase;
    logic [4:0]  eff_step;
    logic [7:0]  eff_held;
    logic        cmd_known;
    logic        held_measure;
    logic [2:0]  start_idx;
    logic [3:0]  bit_inc;

    assign cmd_known = (command_byte == codes.temp_code) ||
                       (command_byte == codes.humidity_code) ||
                       (command_byte == codes.soft_rst_code);
    assign held_measure = (held_reg == codes.temp_code) ||
                          (held_reg == codes.humidity_code);
    assign bit_inc = bit_reg + 4'd1;

    // A start request in idle enters its first phase on the same tick
    always_comb begin
        eff_phase = phase_reg;
        eff_step  = step_reg;
        eff_held  = held_reg;
        if (phase_reg == PH_IDLE) begin
            if (op == OP_CMD && cmd_known) begin
                eff_phase = PH_START;
                eff_step  = '0;
                eff_held  = command_byte;
            end else if (op == OP_RESET) begin
                eff_phase = PH_RST_LO;
                eff_step  = '0;
            end
        end
    end

    assign start_idx = (eff_step < 5'd7) ? eff_step[2:0] : 3'd6;

    // Next state
    always_comb begin
        phase_next   = eff_phase;
        step_next    = eff_step;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        held_next    = eff_held;
        reading_next = reading_reg;
        unique case (eff_phase)
            PH_IDLE: ;
            PH_START: begin
                if (start_idx == 3'd6) begin
                    phase_next = PH_SEND_LO;
                    bit_next   = '0;
                    shift_next = eff_held;
                end else begin
                    step_next = {2'b00, start_idx + 3'd1};
                end
            end
            PH_SEND_LO: phase_next = PH_SEND_HI;
            PH_SEND_HI: begin
                shift_next = {shift_reg[6:0], 1'b0};
                bit_next   = bit_inc;
                phase_next = bit_inc[3] ? PH_ACK_LO : PH_SEND_LO;
            end
            PH_ACK_LO: phase_next = PH_ACK_HI;
            PH_ACK_HI: begin
                step_next  = {4'd0, data_line_in};
                phase_next = PH_ACK_END;
            end
            PH_ACK_END: begin
                if (step_reg == '0 && held_measure) phase_next = PH_WAIT;
                else                                phase_next = PH_IDLE;
            end
            PH_WAIT: begin
                if (!data_line_in) begin
                    phase_next   = PH_RD_LO;
                    bit_next     = '0;
                    reading_next = '0;
                end
            end
            PH_RD_LO: phase_next = PH_RD_HI;
            PH_RD_HI: begin
                reading_next = {reading_reg[14:0], data_line_in};
                bit_next     = bit_inc;
                if (bit_reg == 4'd7)       phase_next = PH_MACK_LO;
                else if (bit_reg == 4'd15) phase_next = PH_FINISH;
                else                       phase_next = PH_RD_LO;
            end
            PH_MACK_LO: phase_next = PH_MACK_HI;
            PH_MACK_HI: phase_next = PH_RD_LO;
            PH_FINISH:  phase_next = PH_IDLE;
            PH_RST_LO: begin
                if (eff_step >= 5'(RESET_CLOCKS)) phase_next = PH_IDLE;
                else                              phase_next = PH_RST_HI;
            end
            PH_RST_HI: begin
                step_next  = step_reg + 5'd1;
                phase_next = PH_RST_LO;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Pin and result outputs
    always_comb begin
        res      = '0;
        res.busy = 1'b1;
        unique case (eff_phase)
            PH_IDLE: begin
                if (op == OP_CMD) begin
                    res.done    = 1'b1;
                    res.status  = ST_INVALID;
                    res.reading = READING_INVALID;
                end else begin
                    res.busy = 1'b0;
                end
            end
            PH_START: begin
                res.data_drive_enable = 1'b1;
                res.clock_level       = start_clk(start_idx);
                res.data_level        = start_dat(start_idx);
            end
            PH_SEND_LO: begin
                res.data_drive_enable = 1'b1;
                res.data_level        = shift_reg[7];
            end
            PH_SEND_HI: begin
                res.data_drive_enable = 1'b1;
                res.clock_level       = 1'b1;
                res.data_level        = shift_reg[7];
            end
            PH_ACK_LO: ;
            PH_ACK_HI: res.clock_level = 1'b1;
            PH_ACK_END: begin
                if (step_reg != '0) begin
                    res.done    = 1'b1;
                    res.status  = ST_NO_ACK;
                    res.reading = READING_NO_ACK;
                end else if (!held_measure) begin
                    res.done = 1'b1;
                end
            end
            PH_WAIT:   ;
            PH_RD_LO:  ;
            PH_RD_HI:  res.clock_level = 1'b1;
            PH_MACK_LO: res.data_drive_enable = 1'b1;
            PH_MACK_HI: begin
                res.data_drive_enable = 1'b1;
                res.clock_level       = 1'b1;
            end
            PH_FINISH: begin
                res.done    = 1'b1;
                res.reading = reading_reg;
            end
            PH_RST_LO: begin
                res.data_drive_enable = 1'b1;
                res.data_level        = 1'b1;
                res.done              = (eff_step >= 5'(RESET_CLOCKS));
            end
            PH_RST_HI: begin
                res.data_drive_enable = 1'b1;
                res.data_level        = 1'b1;
                res.clock_level       = 1'b1;
            end
            default: res.busy = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            step_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            held_reg    <= '0;
            reading_reg <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            held_reg    <= held_next;
            reading_reg <= reading_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_without_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(phase_reg) && $stable(reading_reg))
        else $error("sequencer state moved without a tick");

    a_plain_tick_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && phase_reg == PH_IDLE && op != OP_CMD && op != OP_RESET
        |=> phase_reg == PH_IDLE)
        else $error("plain tick left idle");

    a_reset_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RST_LO || phase_reg == PH_RST_HI)
        |-> step_reg <= 5'(RESET_CLOCKS))
        else $error("connection reset pulse count overran");

    a_send_bit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SEND_LO || phase_reg == PH_SEND_HI) |-> !bit_reg[3])
        else $error("command shift ran past eight bits");
`endif

endmodule

@@ tb/tb_sensor_two_wire_bus_master.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-wire sensor bus master testbench
// Drives bus ticks into the master and checks every tick result against a
// tick-by-tick predictor of the pin sequencer. Directed sequences cover idle
// ticks, rejected codes, connection reset, ignored starts, a missing ack and
// codes rewritten mid-transaction. Random traffic then runs under several
// code settings, with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module tb_sensor_two_wire_bus_master;
    import sh2w_pkg::*;

    localparam int PHASE_ITEMS = 280;   // least number of random items per code setting

    // Predictor of the tick results, with its own copy of codes and sequencer
    class bus_tick_predictor;
        logic [7:0]  temp_code;
        logic [7:0]  humidity_code;
        logic [7:0]  soft_code;
        phase_t      phase;
        logic [4:0]  steps;
        logic [3:0]  bits;
        logic [7:0]  shifter;
        logic [7:0]  held;
        logic [15:0] gathered;
        tick_res_t   expected_ticks[$];
        int          mismatches;

        // Start pattern, tick 0 in bit 0 (both happen to be palindromes)
        bit [6:0]    start_clk_pat = 7'b0110110;
        bit [6:0]    start_dat_pat = 7'b1100011;

        function new();
            temp_code     = 8'd3;
            humidity_code = 8'd5;
            soft_code     = 8'd30;
            phase         = PH_IDLE;
            steps         = '0;
            bits          = '0;
            shifter       = '0;
            held          = '0;
            gathered      = '0;
            mismatches    = 0;
        endfunction

        function void set_codes(logic [7:0] t, logic [7:0] h, logic [7:0] s);
            temp_code     = t;
            humidity_code = h;
            soft_code     = s;
        endfunction

        // One accepted tick: advance the sequencer, queue the pin/result state
        function void note_tick(op_t op, logic [7:0] cmd, logic din);
            tick_res_t  r;
            logic [2:0] s;
            r = '0;
            r.busy = 1'b1;
            if (phase == PH_IDLE) begin
                if (op == OP_CMD) begin
                    if (cmd != temp_code && cmd != humidity_code && cmd != soft_code) begin
                        r.done    = 1'b1;
                        r.status  = ST_INVALID;
                        r.reading = READING_INVALID;
                    end else begin
                        held  = cmd;
                        phase = PH_START;
                        steps = '0;
                    end
                end else if (op == OP_RESET) begin
                    phase = PH_RST_LO;
                    steps = '0;
                end else begin
                    r.busy = 1'b0;
                end
            end

            case (phase)
                PH_IDLE: ;
                PH_START: begin
                    s = (steps < 5'd7) ? steps[2:0] : 3'd6;
                    r.data_drive_enable = 1'b1;
                    r.clock_level       = start_clk_pat[s];
                    r.data_level        = start_dat_pat[s];
                    if (s == 3'd6) begin
                        phase   = PH_SEND_LO;
                        bits    = '0;
                        shifter = held;
                    end else begin
                        steps = 5'(s) + 5'd1;
                    end
                end
                PH_SEND_LO: begin
                    r.data_drive_enable = 1'b1;
                    r.data_level        = shifter[7];
                    phase = PH_SEND_HI;
                end
                PH_SEND_HI: begin
                    r.data_drive_enable = 1'b1;
                    r.clock_level       = 1'b1;
                    r.data_level        = shifter[7];
                    shifter = {shifter[6:0], 1'b0};
                    bits    = bits + 4'd1;
                    phase   = (bits >= 4'd8) ? PH_ACK_LO : PH_SEND_LO;
                end
                PH_ACK_LO: phase = PH_ACK_HI;
                PH_ACK_HI: begin
                    r.clock_level = 1'b1;
                    steps = 5'(din);
                    phase = PH_ACK_END;
                end
                PH_ACK_END: begin
                    // codes are looked up again here, not at the request
                    if (steps != 0) begin
                        r.done    = 1'b1;
                        r.status  = ST_NO_ACK;
                        r.reading = READING_NO_ACK;
                        phase     = PH_IDLE;
                    end else if (held == temp_code || held == humidity_code) begin
                        phase = PH_WAIT;
                    end else begin
                        r.done = 1'b1;
                        phase  = PH_IDLE;
                    end
                end
                PH_WAIT: begin
                    if (!din) begin
                        phase    = PH_RD_LO;
                        bits     = '0;
                        gathered = '0;
                    end
                end
                PH_RD_LO: phase = PH_RD_HI;
                PH_RD_HI: begin
                    r.clock_level = 1'b1;
                    gathered = {gathered[14:0], din};
                    if (bits == 4'd7)       phase = PH_MACK_LO;
                    else if (bits == 4'd15) phase = PH_FINISH;
                    else                    phase = PH_RD_LO;
                    bits = bits + 4'd1;
                end
                PH_MACK_LO: begin
                    r.data_drive_enable = 1'b1;
                    phase = PH_MACK_HI;
                end
                PH_MACK_HI: begin
                    r.data_drive_enable = 1'b1;
                    r.clock_level       = 1'b1;
                    phase = PH_RD_LO;
                end
                PH_FINISH: begin
                    r.done    = 1'b1;
                    r.reading = gathered;
                    phase     = PH_IDLE;
                end
                PH_RST_LO: begin
                    r.data_drive_enable = 1'b1;
                    r.data_level        = 1'b1;
                    if (steps >= RESET_CLOCKS) begin
                        r.done = 1'b1;
                        phase  = PH_IDLE;
                    end else begin
                        phase = PH_RST_HI;
                    end
                end
                PH_RST_HI: begin
                    r.data_drive_enable = 1'b1;
                    r.data_level        = 1'b1;
                    r.clock_level       = 1'b1;
                    steps = steps + 5'd1;
                    phase = PH_RST_LO;
                end
                default: begin
                    r.busy = 1'b0;
                    phase  = PH_IDLE;
                end
            endcase
            expected_ticks.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $error("%s: expected %0h, got %0h", name, exp, act);
                mismatches++;
            end
        endfunction

        // One accepted result item against the oldest expectation
        function void check_tick(logic [23:0] data, logic last);
            tick_res_t e;
            if (expected_ticks.size() == 0) begin
                $error("result item with nothing expected: tdata %0h tlast %0b", data, last);
                mismatches++;
                return;
            end
            e = expected_ticks.pop_front();
            compare_field("clock_level",       e.clock_level,       data[0]);
            compare_field("data_drive_enable", e.data_drive_enable, data[1]);
            compare_field("data_level",        e.data_level,        data[2]);
            compare_field("busy_res",          e.busy,              data[3]);
            compare_field("done_res",          e.done,              last);
            compare_field("status",            e.status,            data[5:4]);
            compare_field("reading",           e.reading,           data[21:6]);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    bus_tick_predictor tick_model;

    // sink stall pattern state
    int          stall_left = 0;
    int          stall_mode = 0;
    int unsigned sink_cycle = 0;

    sensor_two_wire_bus_master DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Sink: switches between always-ready, light, periodic and heavy stalls
    always @(posedge aclk) begin
        sink_cycle <= sink_cycle + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(40, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 9) < 7);
            2:       m_tready <= (sink_cycle % 5 != 4);
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // Result monitor; values read here are the pre-edge ones
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            tick_model.check_tick(m_tdata, m_tlast);
    end

    // Data line level the sensor would present on this tick: mostly ack,
    // a few ticks of conversion wait, random reading bits
    function automatic logic pick_din(phase_t ph);
        logic v;
        case (ph)
            PH_ACK_HI: v = ($urandom_range(0, 9) == 0);
            PH_WAIT:   v = ($urandom_range(0, 2) != 0);
            default:   v = 1'($urandom_range(0, 1));
        endcase
        return v;
    endfunction

    // Present one item and hold it until taken. Valid stays high on return:
    // the caller either sends again or lowers it.
    task automatic send_item(op_t op, logic [7:0] cmd, logic din);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, din, cmd};
        do @(posedge aclk); while (!s_tready);
        tick_model.note_tick(op, cmd, din);
    endtask

    task automatic pause_input(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Stop sending and wait for every expected result item
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tick_model.expected_ticks.size() != 0);
    endtask

    // Write all three codes back to back; only while drained
    task automatic write_codes(logic [7:0] t, logic [7:0] h, logic [7:0] s);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TEMP_CODE;
        cfg_wdata <= t;
        @(posedge aclk);
        cfg_index <= CFG_HUMIDITY_CODE;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_index <= CFG_SOFT_RST_CODE;
        cfg_wdata <= s;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tick_model.set_codes(t, h, s);
    endtask

    // Plain ticks until the sequencer is back in idle
    task automatic run_to_idle();
        while (tick_model.phase != PH_IDLE)
            send_item(OP_TICK, 8'($urandom), pick_din(tick_model.phase));
    endtask

    // Random item: requests mostly valid codes when idle, noise otherwise
    task automatic send_random_item();
        op_t        op;
        logic [7:0] cmd;
        int         pick;
        cmd  = 8'($urandom);
        op   = OP_TICK;
        pick = $urandom_range(0, 99);
        if (tick_model.phase == PH_IDLE) begin
            if (pick < 35) begin
                op  = OP_CMD;
                cmd = tick_model.temp_code;
            end else if (pick < 63) begin
                op  = OP_CMD;
                cmd = tick_model.humidity_code;
            end else if (pick < 76) begin
                op  = OP_CMD;
                cmd = tick_model.soft_code;
            end else if (pick < 84) begin
                op = OP_RESET;
            end else if (pick < 92) begin
                op = OP_CMD;            // random code, usually rejected
            end else if (pick < 96) begin
                op = OP_SPARE;
            end
        end else if (pick < 6) begin
            op = op_t'($urandom_range(0, 3));   // start while busy: ignored
        end
        send_item(op, cmd, pick_din(tick_model.phase));
    endtask

    // Watchdog
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int sent;
        int burst;
        int k;

        tick_model = new();
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_TEMP_CODE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TICK;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // idle ticks, plain and spare op, field extremes
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_SPARE, 8'hFF, 1'b1);
        // codes matching none of the three end on the request tick
        send_item(OP_CMD, 8'h00, 1'b1);
        send_item(OP_CMD, 8'hFF, 1'b0);
        // connection reset with starts thrown at it while busy
        send_item(OP_RESET, 8'h00, 1'b0);
        send_item(OP_CMD, tick_model.temp_code, 1'b0);
        send_item(OP_RESET, 8'h55, 1'b1);
        send_item(OP_SPARE, 8'hAA, 1'b0);
        run_to_idle();
        // soft reset code with the data line left high: no acknowledge
        send_item(OP_CMD, tick_model.soft_code, 1'b1);
        while (tick_model.phase != PH_IDLE)
            send_item(OP_TICK, 8'h00, 1'b1);
        // temperature request whose code is rewritten before the ack check;
        // the held code then matches nothing and ends without a reading
        send_item(OP_CMD, tick_model.temp_code, 1'b0);
        while (tick_model.phase != PH_ACK_LO)
            send_item(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
        wait_drained();
        write_codes(8'h77, tick_model.humidity_code, tick_model.soft_code);
        while (tick_model.phase != PH_IDLE)
            send_item(OP_TICK, 8'h00, 1'b0);
        wait_drained();
        write_codes(8'd3, 8'd5, 8'd30);

        // --- random, one block per code setting ---
        for (int p = 0; p < 5; p++) begin
            wait_drained();
            case (p)
                1:       write_codes(8'h00, 8'hFF, 8'h80);
                2:       write_codes(8'hFF, 8'h00, 8'h01);
                3:       write_codes(8'($urandom), 8'($urandom), 8'($urandom));
                4:       write_codes(8'h5A, 8'h5A, 8'h5A);  // all equal
                default: ;                                  // reset values
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS || tick_model.phase != PH_IDLE) begin
                // long bursts now and then give stretches with no gaps
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 16);
                for (k = 0; k < burst &&
                     (sent < PHASE_ITEMS || tick_model.phase != PH_IDLE); k++) begin
                    send_random_item();
                    sent++;
                end
                pause_input($urandom_range(1, 6));
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (tick_model.mismatches == 0 && tick_model.expected_ticks.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
